>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the clock frame replacer: request and result
// payloads, command and status codes, controller-to-datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    localparam int NUM_FRAMES  = 64;
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int COUNT_W     = FRAME_W + 1;
    localparam int STEP_W      = FRAME_W + 2;
    localparam int CHUNK       = 8;
    localparam int CHUNK_W     = $clog2(CHUNK);
    localparam int CHUNK_IDX_W = FRAME_W - CHUNK_W;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // command codes
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_INSTALL = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_TOUCH   = 3'd3;
    localparam logic [2:0] CMD_PIN     = 3'd4;
    localparam logic [2:0] CMD_UNPIN   = 3'd5;

    // page kinds
    localparam logic [1:0] KIND_RO   = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;

    // writeback actions
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_DROP = 2'd1;
    localparam logic [1:0] WB_FILE = 2'd2;
    localparam logic [1:0] WB_SWAP = 2'd3;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_EVICT = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [FRAME_W-1:0] frame;
        logic [1:0]         page_type;
        logic               is_write;
    } t_item;

    typedef struct packed {
        logic [FRAME_W-1:0] granted_frame;
        logic               evicted;
        logic [1:0]         writeback;
        logic [1:0]         status;
    } t_result;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SCAN,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_EVICT,
        OP_FAIL,
        OP_INST_LINK,
        OP_INST_DONE,
        OP_REL_READ,
        OP_REL_DONE,
        OP_SIMPLE,
        OP_ERROR
    } t_op;

    typedef struct packed {
        logic [2:0] command;
        logic       frame_taken;
        logic       frame_in_ring;
        logic       scan_hit;
        logic       scan_last;
        logic       ring_empty;
        logic       walk_evict;
        logic       walk_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/clock_frame_replacer_unit.sv
// Touch, pin, unpin and errors finish in the decode state; install and release
// go to a ring update state; free-pool alloc scans one 8-frame chunk per cycle.
// Alloc by eviction scans every chunk, then walks the hand up to 2 * ring size steps.
// One request at a time; busy drops in the strobe cycle, the receiver cannot stall.
// Synchronous reset clears all frame flags and the ring at once, no sweep.
// ----------------------------------------------------------------------------
// clock_frame_replacer_unit
// Frame table with second-chance (clock) replacement: top level joining the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_frame_replacer_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire cfr_pkg::t_item            i_item,
    input  wire logic                      i_cfg_we,
    input  wire logic [cfr_pkg::CFG_W-1:0] i_cfg_data,
    output logic                           o_done,
    output cfr_pkg::t_result               o_result
);

    cfr_pkg::t_op      op;
    cfr_pkg::t_dp_stat stat;

    // sequencer
    cfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // frame table and ring
    cfr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/cfr_datapath.sv
// ----------------------------------------------------------------------------
// cfr_datapath
// Frame flags, ring link memories, ring registers and result register.
// Carries out one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire cfr_pkg::t_op              i_op,
    input  wire cfr_pkg::t_item            i_item,
    input  wire logic                      i_cfg_we,
    input  wire logic [cfr_pkg::CFG_W-1:0] i_cfg_data,
    output cfr_pkg::t_dp_stat              o_stat,
    output cfr_pkg::t_result               o_result
);

    localparam int FW = cfr_pkg::FRAME_W;
    localparam int NF = cfr_pkg::NUM_FRAMES;
    localparam int CHUNK_W_L = cfr_pkg::CHUNK_W;

    // latched request
    cfr_pkg::t_item r_item;

    // per-frame flags
    logic [NF-1:0] r_alloc, n_alloc;
    logic [NF-1:0] r_ring, n_ring;
    logic [NF-1:0] r_acc, n_acc;
    logic [NF-1:0] r_dirty, n_dirty;
    logic [NF-1:0] r_pin, n_pin;

    // ring registers
    logic [FW-1:0]                  r_first, n_first;
    logic [FW-1:0]                  r_last, n_last;
    logic [cfr_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [FW-1:0]                  r_hand, n_hand;
    logic                           r_at_end, n_at_end;
    logic [cfr_pkg::STEP_W-1:0]     r_steps, n_steps;
    logic [cfr_pkg::CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic [cfr_pkg::CFG_W-1:0]      r_fiu;
    cfr_pkg::t_result               r_result, n_result;

    // link and kind memories
    logic [FW-1:0] next_mem [NF];
    logic [FW-1:0] prev_mem [NF];
    logic [1:0]    kind_mem [NF];
    logic [FW-1:0] r_next_rd, r_prev_rd;
    logic [1:0]    r_kind_rd;
    logic [FW-1:0] rd_addr;
    logic          next_we, prev_we, kind_we;
    logic [FW-1:0] next_wa, next_wd, prev_wa, prev_wd;

    // scan and walk helpers
    logic                  scan_hit;
    logic [CHUNK_W_L-1:0]  scan_j;
    logic [FW-1:0]         walk_h;
    logic                  rm_en;
    logic [FW-1:0]         rm_f;
    logic [1:0]            wb;

    // find lowest free frame of the current chunk below the pool limit
    always_comb begin
        logic [FW-1:0] idx;
        scan_hit = 1'b0;
        scan_j   = '0;
        for (int j = cfr_pkg::CHUNK - 1; j >= 0; j--) begin
            idx = {r_chunk, CHUNK_W_L'(j)};
            if (!r_alloc[idx] && ({1'b0, idx} < r_fiu)) begin
                scan_hit = 1'b1;
                scan_j   = CHUNK_W_L'(j);
            end
        end
    end

    // advance the hand
    assign walk_h = (r_at_end || r_hand == r_last) ? r_first : r_next_rd;

    // writeback action of the victim
    always_comb begin
        case (r_kind_rd)
            cfr_pkg::KIND_RO:   wb = cfr_pkg::WB_DROP;
            cfr_pkg::KIND_FILE: wb = r_dirty[r_hand] ? cfr_pkg::WB_FILE : cfr_pkg::WB_DROP;
            default:            wb = cfr_pkg::WB_SWAP;
        endcase
    end

    assign rm_en = (i_op == cfr_pkg::OP_EVICT) ||
                   (i_op == cfr_pkg::OP_REL_DONE && r_ring[r_item.frame]);
    assign rm_f  = (i_op == cfr_pkg::OP_EVICT) ? r_hand : r_item.frame;

    // memory read address
    always_comb begin
        case (i_op)
            cfr_pkg::OP_WALK_INIT: rd_addr = r_hand;
            cfr_pkg::OP_WALK_STEP: rd_addr = walk_h;
            default:               rd_addr = r_item.frame;
        endcase
    end

    // next-state logic
    always_comb begin
        n_alloc  = r_alloc;
        n_ring   = r_ring;
        n_acc    = r_acc;
        n_dirty  = r_dirty;
        n_pin    = r_pin;
        n_first  = r_first;
        n_last   = r_last;
        n_count  = r_count;
        n_hand   = r_hand;
        n_at_end = r_at_end;
        n_steps  = r_steps;
        n_chunk  = r_chunk;
        n_result = r_result;
        next_we  = 1'b0;
        prev_we  = 1'b0;
        kind_we  = 1'b0;
        next_wa  = r_item.frame;
        next_wd  = r_item.frame;
        prev_wa  = r_item.frame;
        prev_wd  = r_item.frame;

        case (i_op)
            cfr_pkg::OP_LATCH: begin
                n_chunk = '0;
            end
            cfr_pkg::OP_SCAN: begin
                if (scan_hit) begin
                    n_alloc[{r_chunk, scan_j}] = 1'b1;
                    n_ring[{r_chunk, scan_j}]  = 1'b0;
                    n_acc[{r_chunk, scan_j}]   = 1'b0;
                    n_dirty[{r_chunk, scan_j}] = 1'b0;
                    n_pin[{r_chunk, scan_j}]   = 1'b0;
                    n_result = '{granted_frame: {r_chunk, scan_j}, evicted: 1'b0,
                                 writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_OK};
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            cfr_pkg::OP_WALK_INIT: begin
                n_steps = '0;
            end
            cfr_pkg::OP_WALK_STEP: begin
                n_hand   = walk_h;
                n_at_end = 1'b0;
                n_steps  = r_steps + 1'b1;
                if (!r_pin[walk_h] && r_acc[walk_h]) begin
                    n_acc[walk_h] = 1'b0;
                end
            end
            cfr_pkg::OP_EVICT: begin
                n_alloc[r_hand] = 1'b1;
                n_acc[r_hand]   = 1'b0;
                n_dirty[r_hand] = 1'b0;
                n_pin[r_hand]   = 1'b0;
                n_result = '{granted_frame: r_hand, evicted: 1'b1,
                             writeback: wb, status: cfr_pkg::ST_OK};
            end
            cfr_pkg::OP_FAIL: begin
                n_result = '{granted_frame: '0, evicted: 1'b0,
                             writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_NO_EVICT};
            end
            cfr_pkg::OP_INST_LINK: begin
                prev_we = 1'b1;
                prev_wd = (r_count == '0) ? r_item.frame : r_last;
                if (r_count != '0) begin
                    next_we = 1'b1;
                    next_wa = r_last;
                end
            end
            cfr_pkg::OP_INST_DONE: begin
                next_we = 1'b1;
                kind_we = 1'b1;
                if (r_count == '0) begin
                    n_first = r_item.frame;
                end
                n_last = r_item.frame;
                n_ring[r_item.frame] = 1'b1;
                n_count = r_count + 1'b1;
                n_result = '{granted_frame: '0, evicted: 1'b0,
                             writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_OK};
            end
            cfr_pkg::OP_REL_DONE: begin
                n_alloc[r_item.frame] = 1'b0;
                n_acc[r_item.frame]   = 1'b0;
                n_dirty[r_item.frame] = 1'b0;
                n_pin[r_item.frame]   = 1'b0;
                n_result = '{granted_frame: '0, evicted: 1'b0,
                             writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_OK};
            end
            cfr_pkg::OP_SIMPLE: begin
                case (r_item.command)
                    cfr_pkg::CMD_TOUCH: begin
                        n_acc[r_item.frame] = 1'b1;
                        if (r_item.is_write) begin
                            n_dirty[r_item.frame] = 1'b1;
                        end
                    end
                    cfr_pkg::CMD_PIN:   n_pin[r_item.frame] = 1'b1;
                    default:            n_pin[r_item.frame] = 1'b0;
                endcase
                n_result = '{granted_frame: '0, evicted: 1'b0,
                             writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_OK};
            end
            cfr_pkg::OP_ERROR: begin
                n_result = '{granted_frame: '0, evicted: 1'b0,
                             writeback: cfr_pkg::WB_NONE, status: cfr_pkg::ST_INVALID};
            end
            default: begin
            end
        endcase

        // unlink a frame from the ring
        if (rm_en) begin
            if (!r_at_end && r_hand == rm_f) begin
                if (rm_f == r_last) begin
                    n_at_end = 1'b1;
                end else begin
                    n_hand = r_next_rd;
                end
            end
            if (rm_f == r_first) begin
                n_first = r_next_rd;
            end else begin
                next_we = 1'b1;
                next_wa = r_prev_rd;
                next_wd = r_next_rd;
            end
            if (rm_f == r_last) begin
                n_last = r_prev_rd;
            end else begin
                prev_we = 1'b1;
                prev_wa = r_next_rd;
                prev_wd = r_prev_rd;
            end
            n_ring[rm_f] = 1'b0;
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
            if (r_count <= cfr_pkg::COUNT_W'(1)) begin
                n_first  = '0;
                n_last   = '0;
                n_at_end = 1'b1;
            end
        end
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc  <= '0;
            r_ring   <= '0;
            r_acc    <= '0;
            r_dirty  <= '0;
            r_pin    <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_count  <= '0;
            r_hand   <= '0;
            r_at_end <= 1'b1;
            r_fiu    <= cfr_pkg::CFG_RESET;
        end else begin
            r_alloc  <= n_alloc;
            r_ring   <= n_ring;
            r_acc    <= n_acc;
            r_dirty  <= n_dirty;
            r_pin    <= n_pin;
            r_first  <= n_first;
            r_last   <= n_last;
            r_count  <= n_count;
            r_hand   <= n_hand;
            r_at_end <= n_at_end;
            if (i_cfg_we) begin
                r_fiu <= i_cfg_data;
            end
        end
    end

    // hold payload registers
    always_ff @(posedge i_clk) begin
        if (i_op == cfr_pkg::OP_LATCH) begin
            r_item <= i_item;
        end
        r_steps  <= n_steps;
        r_chunk  <= n_chunk;
        r_result <= n_result;
    end

    // link and kind memories
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (kind_we) begin
            kind_mem[r_item.frame] <= r_item.page_type;
        end
        r_next_rd <= next_mem[rd_addr];
        r_prev_rd <= prev_mem[rd_addr];
        r_kind_rd <= kind_mem[rd_addr];
    end

    // status to the controller
    assign o_stat.command       = r_item.command;
    assign o_stat.frame_taken   = r_alloc[r_item.frame];
    assign o_stat.frame_in_ring = r_ring[r_item.frame];
    assign o_stat.scan_hit      = scan_hit;
    assign o_stat.scan_last     = (r_chunk == '1);
    assign o_stat.ring_empty    = (r_count == '0);
    assign o_stat.walk_evict    = !r_pin[walk_h] && !r_acc[walk_h];
    assign o_stat.walk_last     = ((r_steps + 1'b1) == {r_count, 1'b0});

    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer of the clock frame replacer: decodes a request and steps the
// datapath through free scan, hand walk, eviction and ring updates.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire cfr_pkg::t_dp_stat i_stat,
    output cfr_pkg::t_op           o_op,
    output logic                   o_busy,
    output logic                   o_done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WINIT,
        S_WALK,
        S_EVICT,
        S_FAIL,
        S_INST,
        S_REL
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // pick the datapath operation and the next state
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_op    = cfr_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = cfr_pkg::OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.command == cfr_pkg::CMD_ALLOC) begin
                    n_state = S_SCAN;
                end else if (i_stat.command > cfr_pkg::CMD_UNPIN || !i_stat.frame_taken ||
                             (i_stat.command == cfr_pkg::CMD_INSTALL &&
                              i_stat.frame_in_ring)) begin
                    o_op    = cfr_pkg::OP_ERROR;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else if (i_stat.command == cfr_pkg::CMD_INSTALL) begin
                    o_op    = cfr_pkg::OP_INST_LINK;
                    n_state = S_INST;
                end else if (i_stat.command == cfr_pkg::CMD_RELEASE) begin
                    o_op    = cfr_pkg::OP_REL_READ;
                    n_state = S_REL;
                end else begin
                    o_op    = cfr_pkg::OP_SIMPLE;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_SCAN: begin
                o_op = cfr_pkg::OP_SCAN;
                if (i_stat.scan_hit) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else if (i_stat.scan_last) begin
                    n_state = S_WINIT;
                end
            end
            S_WINIT: begin
                if (i_stat.ring_empty) begin
                    o_op    = cfr_pkg::OP_FAIL;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    o_op    = cfr_pkg::OP_WALK_INIT;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_op = cfr_pkg::OP_WALK_STEP;
                if (i_stat.walk_evict) begin
                    n_state = S_EVICT;
                end else if (i_stat.walk_last) begin
                    n_state = S_FAIL;
                end
            end
            S_EVICT: begin
                o_op    = cfr_pkg::OP_EVICT;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_FAIL: begin
                o_op    = cfr_pkg::OP_FAIL;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_INST: begin
                o_op    = cfr_pkg::OP_INST_DONE;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_REL: begin
                o_op    = cfr_pkg::OP_REL_DONE;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire
